/* rtl/bapp_pkg.sv */
// bapp_pkg: types, register indexes and fixed-point helpers for the
// binomial american put pricer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bapp_pkg;

  localparam logic [63:0] Q30_HALF = 64'h0000_0000_2000_0000;

  typedef enum logic [2:0] {
    CFG_STEPS    = 3'd0,
    CFG_DOWN     = 3'd1,
    CFG_INV_DOWN = 3'd2,
    CFG_UD_RATIO = 3'd3,
    CFG_PROB_UP  = 3'd4,
    CFG_PROB_DN  = 3'd5,
    CFG_DISCOUNT = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DOWN,
    S_DOWN_RND,
    S_FILL,
    S_FILL_WR,
    S_BRD,
    S_B1,
    S_B2,
    S_B3,
    S_B4,
    S_B5,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } rnd_t;

  // round half up from q30, wrap at 64 bits, saturate to 32 bits
  function automatic rnd_t round_q30(input logic [63:0] wide);
    logic [63:0] sum;
    rnd_t        r;
    sum     = wide + Q30_HALF;
    r.sat   = |sum[63:62];
    r.value = r.sat ? 32'hFFFF_FFFF : sum[61:30];
    return r;
  endfunction

  function automatic logic [31:0] exercise(input logic [31:0] k, input logic [31:0] price);
    return (k > price) ? (k - price) : 32'd0;
  endfunction

endpackage

`default_nettype wire

/* rtl/bapp_mul.sv */
// bapp_mul: shared 32x32 multiplier with registered 64-bit product.
// Depends on bapp_pkg for the request type.
`timescale 1ns / 1ps
`default_nettype none

module bapp_mul
  import bapp_pkg::*;
(
  input  wire logic     clk,
  input  wire mul_req_t req,
  output logic [63:0]   prod_r
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= 64'(req.a) * 64'(req.b);
    end
  end

endmodule

`default_nettype wire

/* rtl/binomial_american_put_pricer.sv */
// binomial_american_put_pricer: sequencer, node memories and tree factors.
// Depends on bapp_pkg and bapp_mul.
//
// Usage: each request on the in_ channel (tdata = spot, strike in Q16.16)
// prices one american put by backward induction on a recombining binomial
// tree and gives one request on the out_ channel (tdata = put value Q16.16,
// tuser = saturation flag). The user writes tree factors on the cfg_ channel
// (index, data) while the block is idle (not enforced); cfg_ready is always high.
// Timing: one option at a time, in_tready is low while it is evaluated.
// A single shared multiplier forms every product, four per tree node (two
// blend terms, discount, price step back); the two blend terms are summed
// before one rounding and saturation stage, the others each have their own.
// out_tvalid rises as the block returns to idle, where the next request can
// already be taken.
// The next option is accepted while a finished result waits on the output
// register; if out_tready stays low the following result is held inside
// the block until the register drains.
// Reset (rst_n low, synchronous) restores the default factors and empties
// the output register; node memories need no clearing since every entry is
// written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module binomial_american_put_pricer
  import bapp_pkg::*;
#(
  parameter int MAX_STEPS = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // spot [31:0], strike [63:32]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // put_value [31:0]
  output logic             out_tuser,  // saturated [0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int AW = (MAX_STEPS < 2) ? 1 : $clog2(MAX_STEPS + 1);
  localparam int CW = (AW > 8) ? AW : 8;
  localparam int DEPTH = MAX_STEPS + 1;

  // configuration
  logic [7:0]  steps_r;
  logic [31:0] down_r, inv_down_r, ud_ratio_r;
  logic [30:0] prob_up_r, prob_dn_r, discount_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r    <= 8'd1;
      down_r     <= 32'h4000_0000;
      inv_down_r <= 32'h4000_0000;
      ud_ratio_r <= 32'h4000_0000;
      prob_up_r  <= 31'h2000_0000;
      prob_dn_r  <= 31'h2000_0000;
      discount_r <= 31'h4000_0000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STEPS:    steps_r    <= cfg_data[7:0];
        CFG_DOWN:     down_r     <= cfg_data;
        CFG_INV_DOWN: inv_down_r <= cfg_data;
        CFG_UD_RATIO: ud_ratio_r <= cfg_data;
        CFG_PROB_UP:  prob_up_r  <= cfg_data[30:0];
        CFG_PROB_DN:  prob_dn_r  <= cfg_data[30:0];
        CFG_DISCOUNT: discount_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] steps_ext;
  logic [AW-1:0] n_clamp;
  assign steps_ext = CW'(steps_r);
  assign n_clamp = (steps_ext > CW'(MAX_STEPS)) ? AW'(MAX_STEPS) : AW'(steps_ext);

  // node memories
  logic [31:0] price_mem [DEPTH];
  logic [31:0] value_mem [DEPTH];
  logic        mem_we, rd_en;
  logic [AW-1:0] wr_addr, rd_addr, rd_addr1;
  logic [31:0] wr_price, wr_value;
  logic [31:0] price_rd_r, vi_rd_r, vi1_rd_r;

  assign rd_addr1 = rd_addr + AW'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      price_mem[wr_addr] <= wr_price;
      value_mem[wr_addr] <= wr_value;
    end
    if (rd_en) begin
      price_rd_r <= price_mem[rd_addr];
      vi_rd_r    <= value_mem[rd_addr];
      vi1_rd_r   <= value_mem[rd_addr1];
    end
  end

  // shared multiplier
  mul_req_t    mreq;
  logic [63:0] prod;

  bapp_mul u_mul (
    .clk    (clk),
    .req    (mreq),
    .prod_r (prod)
  );

  // sequencer
  state_t        state_r, state_nxt;
  logic [31:0]   cur_r, cur_nxt;
  logic [31:0]   strike_r, strike_nxt;
  logic [AW-1:0] n_r, n_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] lim_r, lim_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [31:0]   blend_r, blend_nxt;
  logic [31:0]   pnew_r, pnew_nxt;
  logic [31:0]   result_r, result_nxt;
  logic          sat_r, sat_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_data_r, out_data_nxt;
  logic          out_sat_r, out_sat_nxt;

  rnd_t        rnd, blend_rnd;
  logic [31:0] ex_fill, ex_b, node_val;

  assign rnd       = round_q30(prod);
  assign blend_rnd = round_q30(acc_r + prod);
  assign ex_fill   = exercise(strike_r, rnd.value);
  assign ex_b      = exercise(strike_r, pnew_r);
  assign node_val  = (ex_b > rnd.value) ? ex_b : rnd.value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    strike_r   <= strike_nxt;
    n_r        <= n_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    lim_r      <= lim_nxt;
    acc_r      <= acc_nxt;
    blend_r    <= blend_nxt;
    pnew_r     <= pnew_nxt;
    result_r   <= result_nxt;
    sat_r      <= sat_nxt;
    out_data_r <= out_data_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    strike_nxt    = strike_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    lim_nxt       = lim_r;
    acc_nxt       = acc_r;
    blend_nxt     = blend_r;
    pnew_nxt      = pnew_r;
    result_nxt    = result_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_sat_nxt   = out_sat_r;
    in_tready     = 1'b0;
    mreq.en       = 1'b0;
    mreq.a        = cur_r;
    mreq.b        = down_r;
    mem_we        = 1'b0;
    wr_addr       = cnt_r;
    wr_price      = rnd.value;
    wr_value      = ex_fill;
    rd_en         = 1'b0;
    rd_addr       = idx_r;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cur_nxt    = in_tdata[31:0];
          strike_nxt = in_tdata[63:32];
          n_nxt      = n_clamp;
          cnt_nxt    = '0;
          sat_nxt    = 1'b0;
          state_nxt  = S_DOWN;
        end
      end
      S_DOWN: begin
        if (cnt_r == n_r) begin
          mem_we     = 1'b1;
          wr_addr    = '0;
          wr_price   = cur_r;
          wr_value   = exercise(strike_r, cur_r);
          result_nxt = exercise(strike_r, cur_r);
          cnt_nxt    = AW'(1);
          state_nxt  = (n_r == '0) ? S_DONE : S_FILL;
        end else begin
          mreq.en   = 1'b1;
          state_nxt = S_DOWN_RND;
        end
      end
      S_DOWN_RND: begin
        cur_nxt   = rnd.value;
        sat_nxt   = sat_r | rnd.sat;
        cnt_nxt   = cnt_r + AW'(1);
        state_nxt = S_DOWN;
      end
      S_FILL: begin
        mreq.en   = 1'b1;
        mreq.b    = ud_ratio_r;
        state_nxt = S_FILL_WR;
      end
      S_FILL_WR: begin
        cur_nxt = rnd.value;
        sat_nxt = sat_r | rnd.sat;
        mem_we  = 1'b1;
        if (cnt_r == n_r) begin
          idx_nxt   = '0;
          lim_nxt   = n_r - AW'(1);
          state_nxt = S_BRD;
        end else begin
          cnt_nxt   = cnt_r + AW'(1);
          state_nxt = S_FILL;
        end
      end
      S_BRD: begin
        rd_en     = 1'b1;
        state_nxt = S_B1;
      end
      S_B1: begin
        mreq.en   = 1'b1;
        mreq.a    = vi_rd_r;
        mreq.b    = {1'b0, prob_dn_r};
        state_nxt = S_B2;
      end
      S_B2: begin
        acc_nxt   = prod;
        mreq.en   = 1'b1;
        mreq.a    = vi1_rd_r;
        mreq.b    = {1'b0, prob_up_r};
        state_nxt = S_B3;
      end
      S_B3: begin
        blend_nxt = blend_rnd.value;
        sat_nxt   = sat_r | blend_rnd.sat;
        mreq.en   = 1'b1;
        mreq.a    = price_rd_r;
        mreq.b    = inv_down_r;
        state_nxt = S_B4;
      end
      S_B4: begin
        pnew_nxt = rnd.value;
        sat_nxt  = sat_r | rnd.sat;
        mreq.en  = 1'b1;
        mreq.a   = blend_r;
        mreq.b   = {1'b0, discount_r};
        if (idx_r != lim_r) begin
          rd_en   = 1'b1;
          rd_addr = idx_r + AW'(1);
        end
        state_nxt = S_B5;
      end
      S_B5: begin
        sat_nxt  = sat_r | rnd.sat;
        mem_we   = 1'b1;
        wr_addr  = idx_r;
        wr_price = pnew_r;
        wr_value = node_val;
        if (idx_r == '0) begin
          result_nxt = node_val;
        end
        if (idx_r == lim_r) begin
          if (lim_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            lim_nxt   = lim_r - AW'(1);
            idx_nxt   = '0;
            state_nxt = S_BRD;
          end
        end else begin
          idx_nxt   = idx_r + AW'(1);
          mreq.en   = 1'b1;
          mreq.a    = vi_rd_r;
          mreq.b    = {1'b0, prob_dn_r};
          state_nxt = S_B2;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result_r;
          out_sat_nxt   = sat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an option is in progress");

  a_write_in_tree: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> wr_addr <= n_r)
    else $error("node write beyond the tree");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && (!out_valid_r || out_tready) |=> out_tvalid)
    else $error("finished option not presented");

endmodule

`default_nettype wire
